// File: src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hsv2rgb_pkg;

   localparam int HUE_W  = 9;
   localparam int BYTE_W = 8;
   localparam int K_W    = 6;
   localparam int PROD_W = 16;
   localparam int AX_W   = 23;
   localparam int AM_W   = 17;
   localparam int QUO_W  = 9;

   localparam int SECTOR_DEG = 60;
   localparam int FULL_SCALE = 255;

   // Divisors of the rounded quotients floor((2N + D) / (2D)).
   localparam int DEN_X = 2 * FULL_SCALE * SECTOR_DEG;
   localparam int DEN_M = 2 * FULL_SCALE;

   // Reciprocals for the constant divides; the estimate is at most one low.
   localparam int SHIFT_X   = 38;
   localparam int SHIFT_M   = 30;
   localparam int RECIP_X_W = 24;
   localparam int RECIP_M_W = 22;
   localparam logic [RECIP_X_W-1:0] RECIP_X = RECIP_X_W'((64'd1 << SHIFT_X) / DEN_X);
   localparam logic [RECIP_M_W-1:0] RECIP_M = RECIP_M_W'((64'd1 << SHIFT_M) / DEN_M);
   localparam int PX_W = AX_W + RECIP_X_W;
   localparam int PM_W = AM_W + RECIP_M_W;

   typedef enum logic [2:0] {
      SECT_RED_YEL = 3'd0,
      SECT_YEL_GRN = 3'd1,
      SECT_GRN_CYN = 3'd2,
      SECT_CYN_BLU = 3'd3,
      SECT_BLU_MAG = 3'd4,
      SECT_MAG_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic       valid;
      logic       hue_ok;
      sector_type sector;
   } ctrl_type;

endpackage
`default_nettype wire

// File: src/hsv2rgb_sector.sv
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_sector (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    saturation,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    brightness,
   output hsv2rgb_pkg::ctrl_type                  ctrl_out,
   output logic [hsv2rgb_pkg::K_W-1:0]            k_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         sat_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_out
);

   hsv2rgb_pkg::ctrl_type                  ctrl_ff, ctrl_in;
   logic [hsv2rgb_pkg::K_W-1:0]            k_ff, k_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         sat_ff, bri_ff;
   logic [hsv2rgb_pkg::HUE_W-1:0]          base;
   logic [hsv2rgb_pkg::HUE_W-1:0]          offset;
   logic [hsv2rgb_pkg::K_W-1:0]            offset_k;
   logic                                   odd;

   always_comb begin
      ctrl_in.valid  = accept;
      ctrl_in.hue_ok = 1'b1;
      ctrl_in.sector = hsv2rgb_pkg::SECT_RED_YEL;
      base           = '0;
      odd            = 1'b0;
      priority if (hue < hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_DEG)) begin
         ctrl_in.sector = hsv2rgb_pkg::SECT_RED_YEL;
      end else if (hue < hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
         ctrl_in.sector = hsv2rgb_pkg::SECT_YEL_GRN;
         base           = hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_DEG);
         odd            = 1'b1;
      end else if (hue < hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
         ctrl_in.sector = hsv2rgb_pkg::SECT_GRN_CYN;
         base           = hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_DEG);
      end else if (hue < hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
         ctrl_in.sector = hsv2rgb_pkg::SECT_CYN_BLU;
         base           = hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_DEG);
         odd            = 1'b1;
      end else if (hue < hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
         ctrl_in.sector = hsv2rgb_pkg::SECT_BLU_MAG;
         base           = hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_DEG);
      end else if (hue < hsv2rgb_pkg::HUE_W'(6 * hsv2rgb_pkg::SECTOR_DEG)) begin
         ctrl_in.sector = hsv2rgb_pkg::SECT_MAG_RED;
         base           = hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_DEG);
         odd            = 1'b1;
      end else begin
         ctrl_in.hue_ok = 1'b0;
      end
      offset   = hue - base;
      offset_k = offset[hsv2rgb_pkg::K_W-1:0];
      // The secondary weight rises through even sectors and falls through odd ones.
      k_in     = odd ? (hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTOR_DEG) - offset_k) : offset_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.hue_ok <= ctrl_in.hue_ok;
      ctrl_ff.sector <= ctrl_in.sector;
      k_ff           <= k_in;
      sat_ff         <= saturation;
      bri_ff         <= brightness;
   end

   assign ctrl_out = ctrl_ff;
   assign k_out    = k_ff;
   assign sat_out  = sat_ff;
   assign bri_out  = bri_ff;

endmodule
`default_nettype wire

// File: src/hsv2rgb_chroma.sv
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_chroma (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hsv2rgb_pkg::ctrl_type             ctrl_in_s,
   input  wire logic [hsv2rgb_pkg::K_W-1:0]       k,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    saturation,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    brightness,
   output hsv2rgb_pkg::ctrl_type                  ctrl_out,
   output logic [hsv2rgb_pkg::AX_W-1:0]           ax_out,
   output logic [hsv2rgb_pkg::AM_W-1:0]           am_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_out
);

   // First stage: the two 8 by 8 products.
   hsv2rgb_pkg::ctrl_type                  ctrl_a_ff;
   logic [hsv2rgb_pkg::PROD_W-1:0]         vm_ff, vm_in;
   logic [hsv2rgb_pkg::PROD_W-1:0]         vs_ff, vs_in;
   logic [hsv2rgb_pkg::K_W-1:0]            k_ff;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_a_ff;

   // Second stage: the doubled numerators with the rounding half added.
   hsv2rgb_pkg::ctrl_type                  ctrl_b_ff;
   logic [hsv2rgb_pkg::AX_W-1:0]           ax_ff, ax_in;
   logic [hsv2rgb_pkg::AM_W-1:0]           am_ff, am_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_b_ff;
   logic [hsv2rgb_pkg::AX_W-1:0]           numx;

   always_comb begin
      vm_in = hsv2rgb_pkg::PROD_W'(brightness)
            * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::BYTE_W'(hsv2rgb_pkg::FULL_SCALE) - saturation);
      vs_in = hsv2rgb_pkg::PROD_W'(brightness) * hsv2rgb_pkg::PROD_W'(saturation);
   end

   always_comb begin
      numx  = hsv2rgb_pkg::AX_W'(vm_ff) * hsv2rgb_pkg::AX_W'(hsv2rgb_pkg::SECTOR_DEG)
            + hsv2rgb_pkg::AX_W'(vs_ff) * hsv2rgb_pkg::AX_W'(k_ff);
      ax_in = {numx[hsv2rgb_pkg::AX_W-2:0], 1'b0}
            + hsv2rgb_pkg::AX_W'(hsv2rgb_pkg::DEN_X / 2);
      am_in = {vm_ff, 1'b0} + hsv2rgb_pkg::AM_W'(hsv2rgb_pkg::DEN_M / 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff.valid <= 1'b0;
         ctrl_b_ff.valid <= 1'b0;
      end else begin
         ctrl_a_ff.valid <= ctrl_in_s.valid;
         ctrl_b_ff.valid <= ctrl_a_ff.valid;
      end
      ctrl_a_ff.hue_ok <= ctrl_in_s.hue_ok;
      ctrl_a_ff.sector <= ctrl_in_s.sector;
      vm_ff            <= vm_in;
      vs_ff            <= vs_in;
      k_ff             <= k;
      bri_a_ff         <= brightness;
      ctrl_b_ff.hue_ok <= ctrl_a_ff.hue_ok;
      ctrl_b_ff.sector <= ctrl_a_ff.sector;
      ax_ff            <= ax_in;
      am_ff            <= am_in;
      bri_b_ff         <= bri_a_ff;
   end

   assign ctrl_out = ctrl_b_ff;
   assign ax_out   = ax_ff;
   assign am_out   = am_ff;
   assign bri_out  = bri_b_ff;

endmodule
`default_nettype wire

// File: src/hsv2rgb_round.sv
`timescale 1ns / 1ps
`default_nettype none
module hsv2rgb_round (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hsv2rgb_pkg::ctrl_type             ctrl_in_s,
   input  wire logic [hsv2rgb_pkg::AX_W-1:0]      ax,
   input  wire logic [hsv2rgb_pkg::AM_W-1:0]      am,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    brightness,
   output hsv2rgb_pkg::ctrl_type                  ctrl_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         xm_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         mm_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_out
);

   hsv2rgb_pkg::ctrl_type                  ctrl_a_ff;
   logic [hsv2rgb_pkg::PX_W-1:0]           px_ff, px_in;
   logic [hsv2rgb_pkg::PM_W-1:0]           pm_ff, pm_in;
   logic [hsv2rgb_pkg::AX_W-1:0]           ax_ff;
   logic [hsv2rgb_pkg::AM_W-1:0]           am_ff;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_a_ff;

   hsv2rgb_pkg::ctrl_type                  ctrl_b_ff;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         xm_ff, xm_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         mm_ff, mm_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         bri_b_ff;

   logic [hsv2rgb_pkg::QUO_W-1:0]          qx, qm;
   logic [hsv2rgb_pkg::AX_W-1:0]           rx;
   logic [hsv2rgb_pkg::AM_W-1:0]           rm;

   always_comb begin
      px_in = hsv2rgb_pkg::PX_W'(ax) * hsv2rgb_pkg::PX_W'(hsv2rgb_pkg::RECIP_X);
      pm_in = hsv2rgb_pkg::PM_W'(am) * hsv2rgb_pkg::PM_W'(hsv2rgb_pkg::RECIP_M);
   end

   // The reciprocal estimate can fall one short; the remainder check fixes it.
   always_comb begin
      qx    = px_ff[hsv2rgb_pkg::SHIFT_X +: hsv2rgb_pkg::QUO_W];
      qm    = pm_ff[hsv2rgb_pkg::SHIFT_M +: hsv2rgb_pkg::QUO_W];
      rx    = ax_ff - hsv2rgb_pkg::AX_W'(qx) * hsv2rgb_pkg::AX_W'(hsv2rgb_pkg::DEN_X);
      rm    = am_ff - hsv2rgb_pkg::AM_W'(qm) * hsv2rgb_pkg::AM_W'(hsv2rgb_pkg::DEN_M);
      xm_in = (rx >= hsv2rgb_pkg::AX_W'(hsv2rgb_pkg::DEN_X))
            ? hsv2rgb_pkg::BYTE_W'(qx + hsv2rgb_pkg::QUO_W'(1))
            : hsv2rgb_pkg::BYTE_W'(qx);
      mm_in = (rm >= hsv2rgb_pkg::AM_W'(hsv2rgb_pkg::DEN_M))
            ? hsv2rgb_pkg::BYTE_W'(qm + hsv2rgb_pkg::QUO_W'(1))
            : hsv2rgb_pkg::BYTE_W'(qm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff.valid <= 1'b0;
         ctrl_b_ff.valid <= 1'b0;
      end else begin
         ctrl_a_ff.valid <= ctrl_in_s.valid;
         ctrl_b_ff.valid <= ctrl_a_ff.valid;
      end
      ctrl_a_ff.hue_ok <= ctrl_in_s.hue_ok;
      ctrl_a_ff.sector <= ctrl_in_s.sector;
      px_ff            <= px_in;
      pm_ff            <= pm_in;
      ax_ff            <= ax;
      am_ff            <= am;
      bri_a_ff         <= brightness;
      ctrl_b_ff.hue_ok <= ctrl_a_ff.hue_ok;
      ctrl_b_ff.sector <= ctrl_a_ff.sector;
      xm_ff            <= xm_in;
      mm_ff            <= mm_in;
      bri_b_ff         <= bri_a_ff;
   end

   assign ctrl_out = ctrl_b_ff;
   assign xm_out   = xm_ff;
   assign mm_out   = mm_ff;
   assign bri_out  = bri_b_ff;

endmodule
`default_nettype wire

// File: src/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel word per cycle; busy stays low, so start may be held high.
// Stages: sector decode, two 8x8 products, numerator sums, reciprocal multiplies,
// quotient correction, channel select into the output register.
// Reset clears the valid bits of every stage; words in flight are dropped.
// The receiver cannot stall: each result shows for one cycle with rsp_strobe.
module hsv_to_rgb_converter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [hsv2rgb_pkg::HUE_W-1:0]     req_hue,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    req_saturation,
   input  wire logic [hsv2rgb_pkg::BYTE_W-1:0]    req_brightness,
   output logic                                   rsp_strobe,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         rsp_red_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         rsp_green_out,
   output logic [hsv2rgb_pkg::BYTE_W-1:0]         rsp_blue_out
);

   logic                                   accept;
   hsv2rgb_pkg::ctrl_type                  ctrl_s1, ctrl_s3, ctrl_s5;
   logic [hsv2rgb_pkg::K_W-1:0]            k_s1;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         sat_s1, bri_s1, bri_s3, bri_s5;
   logic [hsv2rgb_pkg::AX_W-1:0]           ax_s3;
   logic [hsv2rgb_pkg::AM_W-1:0]           am_s3;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         xm_s5, mm_s5;

   logic                                   strobe_ff;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         red_ff, red_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         green_ff, green_in;
   logic [hsv2rgb_pkg::BYTE_W-1:0]         blue_ff, blue_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   hsv2rgb_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .ctrl_out   (ctrl_s1),
      .k_out      (k_s1),
      .sat_out    (sat_s1),
      .bri_out    (bri_s1)
   );

   hsv2rgb_chroma u_chroma (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in_s  (ctrl_s1),
      .k          (k_s1),
      .saturation (sat_s1),
      .brightness (bri_s1),
      .ctrl_out   (ctrl_s3),
      .ax_out     (ax_s3),
      .am_out     (am_s3),
      .bri_out    (bri_s3)
   );

   hsv2rgb_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in_s  (ctrl_s3),
      .ax         (ax_s3),
      .am         (am_s3),
      .brightness (bri_s3),
      .ctrl_out   (ctrl_s5),
      .xm_out     (xm_s5),
      .mm_out     (mm_s5),
      .bri_out    (bri_s5)
   );

   // A hue past the last sector gives black.
   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      if (ctrl_s5.hue_ok) begin
         unique case (ctrl_s5.sector)
            hsv2rgb_pkg::SECT_RED_YEL: begin
               red_in = bri_s5; green_in = xm_s5;  blue_in = mm_s5;
            end
            hsv2rgb_pkg::SECT_YEL_GRN: begin
               red_in = xm_s5;  green_in = bri_s5; blue_in = mm_s5;
            end
            hsv2rgb_pkg::SECT_GRN_CYN: begin
               red_in = mm_s5;  green_in = bri_s5; blue_in = xm_s5;
            end
            hsv2rgb_pkg::SECT_CYN_BLU: begin
               red_in = mm_s5;  green_in = xm_s5;  blue_in = bri_s5;
            end
            hsv2rgb_pkg::SECT_BLU_MAG: begin
               red_in = xm_s5;  green_in = mm_s5;  blue_in = bri_s5;
            end
            hsv2rgb_pkg::SECT_MAG_RED: begin
               red_in = bri_s5; green_in = mm_s5;  blue_in = xm_s5;
            end
            default: begin
               red_in = '0;     green_in = '0;     blue_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl_s5.valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

endmodule
`default_nettype wire

// File: tb/sv/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
module tb_hsv_to_rgb_converter;
   import hsv2rgb_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 12;

   typedef struct {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_word_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [HUE_W-1:0]  req_hue = '0;
   logic [BYTE_W-1:0] req_saturation = '0;
   logic [BYTE_W-1:0] req_brightness = '0;
   logic              rsp_strobe;
   logic [BYTE_W-1:0] rsp_red_out;
   logic [BYTE_W-1:0] rsp_green_out;
   logic [BYTE_W-1:0] rsp_blue_out;

   rgb_word_t rgb_expected[$];
   int        mismatches = 0;
   int        pixels_sent = 0;
   int        pixels_black_hue = 0;
   int        words_checked = 0;
   int        cycle_count = 0;
   int        sender_gap_max = 0;

   hsv_to_rgb_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still outstanding",
                  cycle_count, rgb_expected.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Exact integer conversion; each channel is scaled to bytes before rounding.
   function automatic rgb_word_t predict_rgb(logic [HUE_W-1:0] hue,
                                             logic [BYTE_W-1:0] sat,
                                             logic [BYTE_W-1:0] val);
      int unsigned       hue_mod;
      int unsigned       ramp;
      int unsigned       val_min;
      logic [BYTE_W-1:0] top_ch;
      logic [BYTE_W-1:0] mid_ch;
      logic [BYTE_W-1:0] low_ch;
      int unsigned       den;
      sector_type        sect;
      rgb_word_t         w;
      w.red = '0;
      w.green = '0;
      w.blue = '0;
      if (hue < 360) begin
         hue_mod = hue % (2 * SECTOR_DEG);
         ramp    = (hue_mod >= SECTOR_DEG) ? (2 * SECTOR_DEG - hue_mod) : hue_mod;
         val_min = val * (FULL_SCALE - sat);
         den     = FULL_SCALE * SECTOR_DEG;
         top_ch  = val;
         mid_ch  = BYTE_W'((2 * (val_min * SECTOR_DEG + val * sat * ramp) + den) / (2 * den));
         low_ch  = BYTE_W'((2 * val_min + FULL_SCALE) / (2 * FULL_SCALE));
         sect    = sector_type'(3'(hue / SECTOR_DEG));
         case (sect)
            SECT_RED_YEL: begin
               w.red = top_ch; w.green = mid_ch; w.blue = low_ch;
            end
            SECT_YEL_GRN: begin
               w.red = mid_ch; w.green = top_ch; w.blue = low_ch;
            end
            SECT_GRN_CYN: begin
               w.red = low_ch; w.green = top_ch; w.blue = mid_ch;
            end
            SECT_CYN_BLU: begin
               w.red = low_ch; w.green = mid_ch; w.blue = top_ch;
            end
            SECT_BLU_MAG: begin
               w.red = mid_ch; w.green = low_ch; w.blue = top_ch;
            end
            default: begin
               w.red = top_ch; w.green = low_ch; w.blue = mid_ch;
            end
         endcase
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 30)
         $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
   endtask

   always @(posedge clock) begin
      rgb_word_t want;
      if (!reset && rsp_strobe) begin
         words_checked++;
         if (rgb_expected.size() == 0) begin
            report_mismatch("unexpected result word, outstanding count", 1, 0);
         end else begin
            want = rgb_expected.pop_front();
            if (rsp_red_out !== want.red)
               report_mismatch("rsp_red_out", rsp_red_out, want.red);
            if (rsp_green_out !== want.green)
               report_mismatch("rsp_green_out", rsp_green_out, want.green);
            if (rsp_blue_out !== want.blue)
               report_mismatch("rsp_blue_out", rsp_blue_out, want.blue);
         end
      end
   end

   // Called and returning at a falling edge; start stays high when no gap follows.
   task automatic send_pixel(logic [HUE_W-1:0] hue, logic [BYTE_W-1:0] sat,
                             logic [BYTE_W-1:0] val);
      int gap;
      gap = (sender_gap_max > 0) ? $urandom_range(0, sender_gap_max) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      do @(posedge clock); while (busy !== 1'b0);
      rgb_expected.push_back(predict_rgb(hue, sat, val));
      pixels_sent++;
      if (hue >= 360)
         pixels_black_hue++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (rgb_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_sector_edges();
      int edges[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
      sender_gap_max = 0;
      foreach (edges[i])
         send_pixel(HUE_W'(edges[i]), 8'd255, 8'd255);
      wait_for_drain();
   endtask

   task automatic test_special_pixels();
      sender_gap_max = 3;
      send_pixel(9'd200, 8'd0, 8'd255);     // gray: no chroma
      send_pixel(9'd90, 8'd255, 8'd0);      // black through zero value
      send_pixel(9'd0, 8'd0, 8'd0);
      send_pixel(9'd360, 8'd255, 8'd255);   // first hue past the circle
      send_pixel(9'd511, 8'd255, 8'd255);   // every hue bit set
      send_pixel(9'd30, 8'd255, 8'd1);      // secondary lands on an exact half
      send_pixel(9'd1, 8'd128, 8'd200);
      send_pixel(9'd330, 8'd170, 8'd85);
      wait_for_drain();
   endtask

   function automatic logic [BYTE_W-1:0] pick_fraction();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 12)
         return '0;
      if (sel < 24)
         return '1;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [HUE_W-1:0] pick_hue();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 8)
         return HUE_W'($urandom_range(360, 511));
      if (sel < 18)
         return HUE_W'(SECTOR_DEG * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 59 : 0));
      return HUE_W'($urandom_range(0, 359));
   endfunction

   // Blocks alternate between random sender gaps and a fully packed stream.
   task automatic test_random_stream(int count);
      int block;
      block = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            sender_gap_max = (block % 2 == 0) ? 10 : 0;
            block++;
         end
         if (n == count / 2)
            wait_for_drain();
         send_pixel(pick_hue(), pick_fraction(), pick_fraction());
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_sector_edges();
      test_special_pixels();
      test_random_stream(850);
      $display("Sent %0d pixels (%0d with hue past 359), checked %0d words,",
               pixels_sent, pixels_black_hue, words_checked);
      $display("covering every sector edge, gray, black and packed or gapped streams.");
      if (mismatches == 0 && rgb_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
